/* hw/rtl/assert_macros.svh */
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define PBSA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Expression that must hold at every clock edge out of reset.
`define PBSA_ASSERT_INV(lbl, clk, rstn, expr, msg) \
  `PBSA_ASSERT(lbl, clk, rstn, (expr), msg)

`endif

/* hw/rtl/pbsa_pkg.sv */
// Types and constants of the picture buffer slot allocator.
package pbsa_pkg;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    HOW_IDLE    = 2'd0,
    HOW_RECLAIM = 2'd1,
    HOW_GROWN   = 2'd2,
    HOW_FORCED  = 2'd3
  } how_e;

  localparam int unsigned OrderW = 31;
  localparam logic [OrderW-1:0] ORDER_LIMIT = 31'h7fffffff;

  typedef struct packed {
    op_e               operation;
    logic [3:0]        slot;
    logic              in_use;
    logic              is_referenced;
    logic              was_output;
    logic              is_done;
    logic [7:0]        holders;
    logic [OrderW-1:0] decode_order;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [3:0] granted_slot;
    how_e       how;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    op_e               kind;
    logic [3:0]        slot;
    logic              used;
    logic              referenced;
    logic              output_done;
    logic              done;
    logic              hold_ok;
    logic [OrderW-1:0] order;
  } cmd_t;

endpackage

/* hw/rtl/pbsa_front.sv */
// Input stage: accepts items, classifies them and queues the commands.
module pbsa_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pbsa_pkg::in_item_t in_item_i,
  output logic             cmd_valid_o,
  output pbsa_pkg::cmd_t   cmd_o,
  input  logic             cmd_pop_i
);
  import pbsa_pkg::*;

  cmd_t       fifo_q [2];
  cmd_t       cmd_new;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       pop;

  always_comb begin
    cmd_new.kind        = in_item_i.operation;
    cmd_new.slot        = in_item_i.slot;
    cmd_new.used        = in_item_i.in_use;
    cmd_new.referenced  = in_item_i.is_referenced;
    cmd_new.output_done = in_item_i.was_output;
    cmd_new.done        = in_item_i.is_done;
    cmd_new.hold_ok     = (in_item_i.holders <= 8'd1);
    cmd_new.order       = in_item_i.decode_order;
  end

  assign in_stall_o  = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* hw/rtl/pbsa_back.sv */
// Slot table and allocation engine with the result register.
module pbsa_back #(
  parameter int unsigned SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  pbsa_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pbsa_pkg::out_item_t out_item_o
);
  import pbsa_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned GW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [SLOTS-1:0]  used_q, used_d;
  logic [SLOTS-1:0]  ref_q, ref_d;
  logic [SLOTS-1:0]  outp_q, outp_d;
  logic [SLOTS-1:0]  done_q, done_d;
  logic [SLOTS-1:0]  hold_q, hold_d;
  logic [GW-1:0]     grown_q, grown_d;

  logic [IW-1:0]     scan_idx_q, scan_idx_d;
  logic              issued_q, issued_d;
  logic              cmp_v_q, cmp_v_d;
  logic [IW-1:0]     cmp_idx_q, cmp_idx_d;
  logic              best_found_q, best_found_d;
  logic [IW-1:0]     best_idx_q, best_idx_d;
  logic [OrderW-1:0] best_order_q, best_order_d;
  logic [OrderW-1:0] rd_order_q;
  logic [OrderW-1:0] order_mem [SLOTS];

  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic              out_load;
  logic              out_free;

  logic              mem_we;
  logic [IW-1:0]     slot_idx;
  logic [IW-1:0]     grow_idx;
  logic              in_range;
  logic              can_grow;
  logic [SLOTS-1:0]  grown_mask;
  logic [SLOTS-1:0]  t1_vec, t2_vec, t4_vec;
  logic [IW-1:0]     t1_idx, t2_idx;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign slot_idx    = IW'(cmd_i.slot);
  assign grow_idx    = IW'(grown_q);
  assign in_range    = (32'(cmd_i.slot) < 32'(grown_q));
  assign can_grow    = (grown_q < GW'(SLOTS));

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      grown_mask[i] = (i < int'(grown_q));
    end
  end

  assign t1_vec = grown_mask & ~used_q;
  assign t2_vec = grown_mask & used_q & ~ref_q & outp_q & hold_q;
  assign t4_vec = grown_mask & used_q & done_q & ~ref_q & hold_q;

  always_comb begin
    t1_idx = '0;
    t2_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (t1_vec[i]) begin
        t1_idx = IW'(i);
      end
      if (t2_vec[i]) begin
        t2_idx = IW'(i);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    ref_d        = ref_q;
    outp_d       = outp_q;
    done_d       = done_q;
    hold_d       = hold_q;
    grown_d      = grown_q;
    scan_idx_d   = scan_idx_q;
    issued_d     = issued_q;
    cmp_v_d      = cmp_v_q;
    cmp_idx_d    = cmp_idx_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_order_d = best_order_q;
    cmd_pop_o    = 1'b0;
    mem_we       = 1'b0;
    out_load     = 1'b0;
    out_d.found        = 1'b0;
    out_d.granted_slot = 4'd0;
    out_d.how          = HOW_IDLE;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            OP_REQUEST: begin
              if (out_free) begin
                cmd_pop_o = 1'b1;
                if (|t1_vec) begin
                  out_load           = 1'b1;
                  out_d.found        = 1'b1;
                  out_d.granted_slot = 4'(t1_idx);
                  out_d.how          = HOW_IDLE;
                end else if (|t2_vec) begin
                  used_d[t2_idx]     = 1'b0;
                  out_load           = 1'b1;
                  out_d.found        = 1'b1;
                  out_d.granted_slot = 4'(t2_idx);
                  out_d.how          = HOW_RECLAIM;
                end else if (can_grow) begin
                  used_d[grow_idx]   = 1'b0;
                  ref_d[grow_idx]    = 1'b0;
                  outp_d[grow_idx]   = 1'b0;
                  done_d[grow_idx]   = 1'b0;
                  hold_d[grow_idx]   = 1'b1;
                  grown_d            = grown_q + 1'b1;
                  out_load           = 1'b1;
                  out_d.found        = 1'b1;
                  out_d.granted_slot = 4'(grow_idx);
                  out_d.how          = HOW_GROWN;
                end else if (|t4_vec) begin
                  state_d      = ST_SCAN;
                  scan_idx_d   = '0;
                  issued_d     = 1'b0;
                  cmp_v_d      = 1'b0;
                  best_found_d = 1'b0;
                  best_idx_d   = '0;
                  best_order_d = ORDER_LIMIT;
                end else begin
                  out_load = 1'b1;
                end
              end
            end
            OP_WRITE: begin
              cmd_pop_o = 1'b1;
              if (in_range) begin
                used_d[slot_idx] = cmd_i.used;
                ref_d[slot_idx]  = cmd_i.referenced;
                outp_d[slot_idx] = cmd_i.output_done;
                done_d[slot_idx] = cmd_i.done;
                hold_d[slot_idx] = cmd_i.hold_ok;
                mem_we           = 1'b1;
              end
            end
            OP_RELEASE: begin
              cmd_pop_o = 1'b1;
              if (in_range) begin
                used_d[slot_idx] = 1'b0;
              end
            end
            OP_CLEAR: begin
              cmd_pop_o = 1'b1;
              used_d    = '0;
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!issued_q) begin
          cmp_v_d   = 1'b1;
          cmp_idx_d = scan_idx_q;
          if (scan_idx_q == IW'(SLOTS - 1)) begin
            issued_d = 1'b1;
          end else begin
            scan_idx_d = scan_idx_q + 1'b1;
          end
        end else begin
          cmp_v_d = 1'b0;
        end
        if (cmp_v_q) begin
          if (t4_vec[cmp_idx_q] && (rd_order_q < best_order_q)) begin
            best_found_d = 1'b1;
            best_idx_d   = cmp_idx_q;
            best_order_d = rd_order_q;
          end
          if (cmp_idx_q == IW'(SLOTS - 1)) begin
            state_d = ST_EMIT;
            cmp_v_d = 1'b0;
          end
        end
      end
      ST_EMIT: begin
        out_load = 1'b1;
        state_d  = ST_IDLE;
        if (best_found_q) begin
          used_d[best_idx_q] = 1'b0;
          out_d.found        = 1'b1;
          out_d.granted_slot = 4'(best_idx_q);
          out_d.how          = HOW_FORCED;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      order_mem[slot_idx] <= cmd_i.order;
    end
    rd_order_q <= order_mem[scan_idx_q];
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      used_q       <= '0;
      ref_q        <= '0;
      outp_q       <= '0;
      done_q       <= '0;
      hold_q       <= '1;
      grown_q      <= '0;
      scan_idx_q   <= '0;
      issued_q     <= 1'b0;
      cmp_v_q      <= 1'b0;
      cmp_idx_q    <= '0;
      best_found_q <= 1'b0;
      best_idx_q   <= '0;
      best_order_q <= ORDER_LIMIT;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      ref_q        <= ref_d;
      outp_q       <= outp_d;
      done_q       <= done_d;
      hold_q       <= hold_d;
      grown_q      <= grown_d;
      scan_idx_q   <= scan_idx_d;
      issued_q     <= issued_d;
      cmp_v_q      <= cmp_v_d;
      cmp_idx_q    <= cmp_idx_d;
      best_found_q <= best_found_d;
      best_idx_q   <= best_idx_d;
      best_order_q <= best_order_d;
      out_valid_q  <= out_valid_d;
    end
  end

endmodule

/* hw/rtl/picture_buffer_slot_allocator.sv */
// Picture buffer slot allocator: a two-entry command queue in front of the slot engine.
// Items enter a two-entry command queue and are carried out one at a time by the slot
// engine. Write, release and clear are carried out straight from its idle state, and so
// is a request answered by an idle slot, a reclaimed output slot or a newly grown slot,
// once the output register is free; it passes the queue, then the output register.
// A request that falls through to the oldest-picture search walks the coding-order
// memory one slot per cycle in its scan state, then loads its result in the emit state.
// Results are held in an output register; the queue keeps accepting items, while it
// has room, as a result waits there. One result per request, none for other operations.
module picture_buffer_slot_allocator #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pbsa_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pbsa_pkg::out_item_t out_item_o
);
  import pbsa_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  pbsa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  pbsa_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* hw/rtl/pbsa_checker.sv */
// Port-level checks of the picture buffer slot allocator and their bind.
`include "assert_macros.svh"

module pbsa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input pbsa_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pbsa_pkg::out_item_t out_item_o
);
  import pbsa_pkg::*;

  logic [3:0] pending_q, pending_d;
  logic       req_xfer;
  logic       res_xfer;

  assign req_xfer = in_valid_i && !in_stall_o && (in_item_i.operation == OP_REQUEST);
  assign res_xfer = out_valid_o && !out_stall_i;

  always_comb begin
    pending_d = pending_q + {3'd0, req_xfer} - {3'd0, res_xfer};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 4'd0;
    end else begin
      pending_q <= pending_d;
    end
  end

  `PBSA_ASSERT(a_no_unrequested_result, clk_i, rst_ni, res_xfer |-> pending_q != 4'd0, "result transfer without an outstanding request")
  `PBSA_ASSERT(a_stalled_result_holds, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o), "stalled result changed or dropped")
  `PBSA_ASSERT_INV(a_pending_bounded, clk_i, rst_ni, pending_q <= 4'd4, "more requests in flight than the block can hold")

endmodule

bind picture_buffer_slot_allocator pbsa_checker u_pbsa_checker (.*);

/* dv/tb_picture_buffer_slot_allocator.sv */
// Self-checking testbench for the picture buffer slot allocator.
`timescale 1ns / 1ps

module tb_picture_buffer_slot_allocator;
  import pbsa_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = SLOTS + 8;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  picture_buffer_slot_allocator #(
    .SLOTS(SLOTS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  logic [4:0]        grown_count;
  logic              slot_used[SLOTS];
  logic              slot_refd[SLOTS];
  logic              slot_shown[SLOTS];
  logic              slot_done[SLOTS];
  logic [7:0]        slot_holders[SLOTS];
  logic [OrderW-1:0] slot_order[SLOTS];

  out_item_t   grants_due[$];
  out_item_t   last_grant;
  int unsigned how_count[4] = '{0, 0, 0, 0};
  int unsigned refusals = 0;
  int unsigned items_in = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  bit          in_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;

  function automatic out_item_t grant_slot();
    out_item_t         g;
    int                best;
    logic [OrderW-1:0] best_order;
    g = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (i < grown_count && !slot_used[i]) begin
        g.found = 1'b1;
        g.granted_slot = 4'(i);
        g.how = HOW_IDLE;
        return g;
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (i < grown_count && slot_used[i] && !slot_refd[i] && slot_shown[i] &&
          slot_holders[i] <= 8'd1) begin
        slot_used[i] = 1'b0;
        g.found = 1'b1;
        g.granted_slot = 4'(i);
        g.how = HOW_RECLAIM;
        return g;
      end
    end
    if (grown_count < SLOTS) begin
      slot_used[grown_count]    = 1'b0;
      slot_refd[grown_count]    = 1'b0;
      slot_shown[grown_count]   = 1'b0;
      slot_done[grown_count]    = 1'b0;
      slot_holders[grown_count] = '0;
      slot_order[grown_count]   = '0;
      g.found = 1'b1;
      g.granted_slot = grown_count[3:0];
      g.how = HOW_GROWN;
      grown_count = grown_count + 5'd1;
      return g;
    end
    best = -1;
    best_order = ORDER_LIMIT;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_done[i] && !slot_refd[i] && slot_holders[i] <= 8'd1 &&
          slot_order[i] < best_order) begin
        best_order = slot_order[i];
        best = i;
      end
    end
    if (best >= 0) begin
      slot_used[best] = 1'b0;
      g.found = 1'b1;
      g.granted_slot = 4'(best);
      g.how = HOW_FORCED;
    end
    return g;
  endfunction

  task automatic track_item(input in_item_t it);
    items_in++;
    case (it.operation)
      OP_REQUEST: begin
        last_grant = grant_slot();
        grants_due.push_back(last_grant);
        if (last_grant.found) how_count[last_grant.how]++;
        else refusals++;
      end
      OP_WRITE: begin
        if (it.slot < grown_count) begin
          slot_used[it.slot]    = it.in_use;
          slot_refd[it.slot]    = it.is_referenced;
          slot_shown[it.slot]   = it.was_output;
          slot_done[it.slot]    = it.is_done;
          slot_holders[it.slot] = it.holders;
          slot_order[it.slot]   = it.decode_order;
        end
      end
      OP_RELEASE: begin
        if (it.slot < grown_count) slot_used[it.slot] = 1'b0;
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (i < grown_count) slot_used[i] = 1'b0;
        end
      end
    endcase
  endtask

  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [OrderW-1:0] pick_order();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return ORDER_LIMIT;
    if (r < 4) return OrderW'($urandom_range(0, 7));
    return OrderW'($urandom);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.operation     = op_e'($urandom_range(0, 3));
    it.slot          = 4'($urandom_range(0, 15));
    it.in_use        = 1'($urandom_range(0, 1));
    it.is_referenced = 1'($urandom_range(0, 1));
    it.was_output    = 1'($urandom_range(0, 1));
    it.is_done       = 1'($urandom_range(0, 1));
    it.holders       = 8'($urandom_range(0, 255));
    it.decode_order  = OrderW'($urandom);
    return it;
  endfunction

  function automatic in_item_t status_write(input logic [3:0] s);
    in_item_t    it;
    int unsigned r;
    it.operation     = OP_WRITE;
    it.slot          = s;
    it.in_use        = ($urandom_range(0, 9) != 0);
    it.is_referenced = ($urandom_range(0, 9) < 3);
    it.was_output    = 1'($urandom_range(0, 1));
    it.is_done       = ($urandom_range(0, 9) < 6);
    r = $urandom_range(0, 9);
    if (r < 7) it.holders = 8'($urandom_range(0, 1));
    else if (r < 9) it.holders = 8'($urandom_range(2, 3));
    else it.holders = 8'($urandom_range(0, 255));
    it.decode_order = pick_order();
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = pick_gap(in_idle_on);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) begin
        in_item_i = random_item();
        @(negedge clk_i);
      end
    end
    in_valid_i = 1'b1;
    in_item_i = it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_item(it);
    @(negedge clk_i);
  endtask

  task automatic request_slot();
    in_item_t it;
    it = random_item();
    it.operation = OP_REQUEST;
    send_item(it);
  endtask

  task automatic write_slot(input logic [3:0] s, input bit u, r, o, d,
                            input logic [7:0] h, input logic [OrderW-1:0] ord);
    in_item_t it;
    it.operation     = OP_WRITE;
    it.slot          = s;
    it.in_use        = u;
    it.is_referenced = r;
    it.was_output    = o;
    it.is_done       = d;
    it.holders       = h;
    it.decode_order  = ord;
    send_item(it);
  endtask

  task automatic release_slot(input logic [3:0] s);
    in_item_t it;
    it = random_item();
    it.operation = OP_RELEASE;
    it.slot = s;
    send_item(it);
  endtask

  task automatic clear_all();
    in_item_t it;
    it = random_item();
    it.operation = OP_CLEAR;
    send_item(it);
  endtask

  task automatic test_growth_and_reuse();
    in_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    release_slot(4'd0);
    write_slot(4'd3, 1, 1, 1, 1, 8'd255, ORDER_LIMIT);
    clear_all();
    request_slot();
    request_slot();
    write_slot(4'd0, 1, 0, 1, 1, 8'd2, '0);
    request_slot();
    write_slot(4'd1, 1, 0, 1, 0, 8'd1, ORDER_LIMIT);
    request_slot();
    request_slot();
    write_slot(4'd1, 1, 1, 1, 1, 8'd0, 31'd5);
    write_slot(4'd0, 1, 0, 1, 1, 8'd0, 31'd9);
    request_slot();
    release_slot(4'd1);
    request_slot();
    write_slot(4'd15, 1, 0, 1, 1, 8'd255, ORDER_LIMIT);
    clear_all();
    request_slot();
  endtask

  task automatic test_full_table();
    in_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (grown_count < SLOTS) begin
      request_slot();
      write_slot(last_grant.granted_slot, 1, 0, 0, 1, 8'($urandom_range(0, 1)),
                 OrderW'($urandom_range(100, 1000)));
    end
    in_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    write_slot(4'd2, 1, 1, 0, 1, 8'd0, '0);
    write_slot(4'd7, 1, 0, 0, 1, 8'd2, '0);
    write_slot(4'd11, 1, 0, 0, 0, 8'd0, 31'd1);
    write_slot(4'd5, 1, 0, 0, 1, 8'd1, 31'd3);
    write_slot(4'd9, 1, 0, 0, 1, 8'd0, 31'd3);
    request_slot();
    write_slot(4'd5, 1, 0, 0, 1, 8'd0, 31'd50);
    request_slot();
    for (int i = 0; i < SLOTS; i++) write_slot(4'(i), 1, 0, 0, 1, 8'd0, ORDER_LIMIT);
    request_slot();
    write_slot(4'd15, 1, 0, 0, 1, 8'd1, ORDER_LIMIT - 31'd1);
    request_slot();
    write_slot(4'd15, 1, 0, 1, 1, 8'd0, ORDER_LIMIT);
    request_slot();
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned next_phase;
    int unsigned r;
    sent = 0;
    next_phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= next_phase) begin
        in_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
        next_phase = next_phase + 100;
      end
      r = $urandom_range(0, 99);
      if (r < 40) begin
        request_slot();
        sent++;
        if (last_grant.found && $urandom_range(0, 4) != 0) begin
          send_item(status_write(last_grant.granted_slot));
          sent++;
        end
      end else begin
        if (r < 70) send_item(status_write(4'($urandom_range(0, SLOTS - 1))));
        else if (r < 85) release_slot(4'($urandom_range(0, SLOTS - 1)));
        else if (r < 87) clear_all();
        else send_item(random_item());
        sent++;
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    int unsigned hold_left;
    int unsigned r;
    out_stall_i = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) hold_left--;
      else if (!rx_idle_on) out_stall_i = 1'b0;
      else begin
        r = $urandom_range(0, 99);
        out_stall_i = (r < 35);
        if (!out_stall_i) hold_left = $urandom_range(0, 4);
        else if (r < 32) hold_left = $urandom_range(0, 2);
        else hold_left = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (grants_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected result: found=%0d slot=%0d how=%0d", $time,
                   out_item_o.found, out_item_o.granted_slot, out_item_o.how);
      end else begin
        want = grants_due.pop_front();
        if (out_item_o.found !== want.found || out_item_o.granted_slot !== want.granted_slot ||
            out_item_o.how !== want.how) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] grant mismatch: expected found=%0d slot=%0d how=%0d, got found=%0d slot=%0d how=%0d",
                     $time, want.found, want.granted_slot, want.how,
                     out_item_o.found, out_item_o.granted_slot, out_item_o.how);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, grants_due.size());
        $display("picture_buffer_slot_allocator verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    grown_count = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i]    = 1'b0;
      slot_refd[i]    = 1'b0;
      slot_shown[i]   = 1'b0;
      slot_done[i]    = 1'b0;
      slot_holders[i] = '0;
      slot_order[i]   = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_growth_and_reuse();
    test_full_table();
    test_random_traffic();

    in_valid_i = 1'b0;
    while (grants_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d items sent, %0d grants checked: %0d idle, %0d reclaimed, %0d grown, %0d forced",
             items_in, results_seen, how_count[HOW_IDLE], how_count[HOW_RECLAIM],
             how_count[HOW_GROWN], how_count[HOW_FORCED]);
    $display("%0d requests refused, %0d mismatched or unexpected results", refusals, errors);
    if (errors == 0) begin
      $display("picture_buffer_slot_allocator verification clean");
    end else begin
      $display("picture_buffer_slot_allocator verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/pbsa_pkg.sv
hw/rtl/pbsa_front.sv
hw/rtl/pbsa_back.sv
hw/rtl/picture_buffer_slot_allocator.sv
hw/rtl/pbsa_checker.sv
dv/tb_picture_buffer_slot_allocator.sv
